// ===== hw/rtl/stq_pkg.sv =====
package stq_pkg;

	// Defaults for the top-level parameters
	localparam int NUM_TIMERS_DEF = 16;
	localparam int TIME_BITS_DEF  = 32;

	// Fixed field widths of the command and result words
	localparam int CMD_W     = 3;
	localparam int ID_W      = 4;
	localparam int ID_COUNT  = 1 << ID_W;
	localparam int IN_TIME_W = 32;

	// At most this many timers fire on one tick
	localparam int MAX_FIRE   = 16;
	localparam int FIRE_CNT_W = $clog2(MAX_FIRE + 1);

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_MODIFY  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MOD_PND = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;

	// Operation broadcast to every cell of the chain
	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_POP    = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t          code;
		logic [ID_W-1:0]   id;
	} stq_op_t;

	// Flags handed from each cell to its right neighbor
	typedef struct packed {
		logic ins;  // new key sorts at or before this cell
		logic hit;  // matching owner found at or before this cell
	} stq_link_t;

endpackage

// ===== hw/rtl/stq_ifs.sv =====
interface stq_req_if import stq_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      cmd;
	logic [ID_W-1:0]       timer_id;
	logic [IN_TIME_W-1:0]  expiry_time;
	logic [IN_TIME_W-1:0]  current_time;

	modport source(output valid, cmd, timer_id, expiry_time, current_time, input ready);
	modport sink(input valid, cmd, timer_id, expiry_time, current_time, output ready);
endinterface

interface stq_rsp_if import stq_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             was_pending;
	logic             fault;
	logic             fired;
	logic [ID_W-1:0]  fired_id;
	logic             last;

	modport source(output valid, was_pending, fault, fired, fired_id, last, input ready);
	modport sink(input valid, was_pending, fault, fired, fired_id, last, output ready);
endinterface

// ===== hw/rtl/stq_cell.sv =====
module stq_cell import stq_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  stq_op_t              op,
	input  logic [TIME_BITS-1:0] key,
	input  stq_link_t            from_left,
	output stq_link_t            to_right,
	input  logic                 left_valid,
	input  logic [TIME_BITS-1:0] left_expiry,
	input  logic [ID_W-1:0]      left_owner,
	input  logic                 right_valid,
	input  logic [TIME_BITS-1:0] right_expiry,
	input  logic [ID_W-1:0]      right_owner,
	output logic                 valid,
	output logic [TIME_BITS-1:0] expiry,
	output logic [ID_W-1:0]      owner
);

	logic                 valid_q;
	logic [TIME_BITS-1:0] expiry_q;
	logic [ID_W-1:0]      owner_q;
	logic                 ins_here;
	logic                 hit_here;
	logic                 valid_d;
	logic [TIME_BITS-1:0] expiry_d;
	logic [ID_W-1:0]      owner_d;

	// An empty cell sorts as later than any key; equal keys go behind
	assign ins_here = !valid_q || (key < expiry_q);
	assign hit_here = from_left.hit || (valid_q && (owner_q == op.id));
	assign to_right = '{ins: ins_here, hit: hit_here};

	// Next contents: hold, take new key, take left (shift right) or right (shift left)
	always_comb begin
		valid_d  = valid_q;
		expiry_d = expiry_q;
		owner_d  = owner_q;
		unique case (op.code)
			OP_INSERT: begin
				if (ins_here) begin
					if (from_left.ins) begin
						valid_d  = left_valid;
						expiry_d = left_expiry;
						owner_d  = left_owner;
					end else begin
						valid_d  = 1'b1;
						expiry_d = key;
						owner_d  = op.id;
					end
				end
			end
			OP_REMOVE: begin
				if (hit_here) begin
					valid_d  = right_valid;
					expiry_d = right_expiry;
					owner_d  = right_owner;
				end
			end
			OP_POP: begin
				valid_d  = right_valid;
				expiry_d = right_expiry;
				owner_d  = right_owner;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	// Payload carries no reset
	always_ff @(posedge clk) begin
		expiry_q <= expiry_d;
		owner_q  <= owner_d;
	end

	assign valid  = valid_q;
	assign expiry = expiry_q;
	assign owner  = owner_q;

endmodule

// ===== hw/rtl/sorted_timer_queue.sv =====
// Sorted timer queue: holds up to NUM_TIMERS numbered timers (ids 0 to 15, and below
// NUM_TIMERS) in a row of cells ordered by expiry, equal expiries in insertion order.
// One command word is taken at a time and each gives one result word, except a tick,
// which gives one word per fired timer (at most 16, head first) or a single empty word.
// Add or modify of a timer not pending inserts it and then loads the result; delete
// of a pending timer removes it first, either modify of a pending timer removes it and
// reinserts it, and an add that faults, delete or modify-if-pending of a timer not
// pending, a bad id and an unknown code go straight to loading the result. The cell
// row does one insert, one removal or one head pop per cycle; a tick pops no timer
// while a result word waits on ready, and no command is taken until the last result
// word is loaded. Times are cut or zero-extended to TIME_BITS and compared unsigned
// with no wrap handling. Expiry and owner cells carry no reset.
module sorted_timer_queue import stq_pkg::*; #(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	stq_req_if.sink   req,
	stq_rsp_if.source rsp
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DETACH = 5'b00010,
		S_INSERT = 5'b00100,
		S_REPLY  = 5'b01000,
		S_TICK   = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [ID_COUNT-1:0]    pending_q;
	logic [ID_W-1:0]        id_q;
	logic [TIME_BITS-1:0]   exp_q;
	logic [TIME_BITS-1:0]   now_q;
	logic                   was_q;
	logic                   flt_q;
	logic                   del_q;
	logic [FIRE_CNT_W-1:0]  fire_cnt_q;

	logic                   rsp_valid_q;
	logic                   rsp_was_q;
	logic                   rsp_flt_q;
	logic                   rsp_fired_q;
	logic [ID_W-1:0]        rsp_id_q;
	logic                   rsp_last_q;

	logic                   cell_valid [NUM_TIMERS];
	logic [TIME_BITS-1:0]   cell_expiry [NUM_TIMERS];
	logic [ID_W-1:0]        cell_owner [NUM_TIMERS];
	stq_link_t              cell_link [NUM_TIMERS];

	stq_op_t                op;
	logic                   accept;
	logic                   slot_free;
	logic                   rsp_load;
	logic                   id_ok;
	logic                   pend;
	logic                   tail_full;
	logic                   fire_ok;
	logic                   more_due;
	logic                   last_fire;

	assign accept    = req.valid && req.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign rsp_load  = slot_free && ((state_q == S_REPLY) || (state_q == S_TICK));
	assign id_ok     = int'(req.timer_id) < NUM_TIMERS;
	assign pend      = id_ok && pending_q[req.timer_id];
	assign tail_full = cell_valid[NUM_TIMERS-1];

	// Head and second cell decide firing and whether this word is the last one
	assign fire_ok   = cell_valid[0] && (cell_expiry[0] <= now_q) &&
	                   (fire_cnt_q < FIRE_CNT_W'(MAX_FIRE));
	assign more_due  = cell_valid[1] && (cell_expiry[1] <= now_q) &&
	                   (fire_cnt_q < FIRE_CNT_W'(MAX_FIRE - 1));
	assign last_fire = !more_due;

	assign req.ready = (state_q == S_IDLE);

	// Operation for the cell row
	always_comb begin
		op.id   = id_q;
		op.code = OP_NONE;
		unique case (state_q)
			S_DETACH: op.code = OP_REMOVE;
			S_INSERT: op.code = tail_full ? OP_NONE : OP_INSERT;
			S_TICK:   op.code = (slot_free && fire_ok) ? OP_POP : OP_NONE;
			default:  op.code = OP_NONE;
		endcase
	end

	// Cell row
	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		stq_link_t            left_link;
		logic                 l_valid;
		logic [TIME_BITS-1:0] l_expiry;
		logic [ID_W-1:0]      l_owner;
		logic                 r_valid;
		logic [TIME_BITS-1:0] r_expiry;
		logic [ID_W-1:0]      r_owner;

		if (i == 0) begin : g_head
			assign left_link = '0;
			assign l_valid   = 1'b0;
			assign l_expiry  = exp_q;
			assign l_owner   = id_q;
		end else begin : g_mid
			assign left_link = cell_link[i-1];
			assign l_valid   = cell_valid[i-1];
			assign l_expiry  = cell_expiry[i-1];
			assign l_owner   = cell_owner[i-1];
		end

		if (i == NUM_TIMERS - 1) begin : g_tail
			assign r_valid  = 1'b0;
			assign r_expiry = cell_expiry[i];
			assign r_owner  = cell_owner[i];
		end else begin : g_body
			assign r_valid  = cell_valid[i+1];
			assign r_expiry = cell_expiry[i+1];
			assign r_owner  = cell_owner[i+1];
		end

		stq_cell #(
			.TIME_BITS(TIME_BITS)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.op           (op),
			.key          (exp_q),
			.from_left    (left_link),
			.to_right     (cell_link[i]),
			.left_valid   (l_valid),
			.left_expiry  (l_expiry),
			.left_owner   (l_owner),
			.right_valid  (r_valid),
			.right_expiry (r_expiry),
			.right_owner  (r_owner),
			.valid        (cell_valid[i]),
			.expiry       (cell_expiry[i]),
			.owner        (cell_owner[i])
		);
	end

	// Command sequencer, pending marks and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pending_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Load a new result word, or drop the one just taken
			rsp_valid_q <= rsp_load || (rsp_valid_q && !rsp.ready);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.cmd == CMD_TICK) begin
							state_q <= S_TICK;
						end else if (!id_ok) begin
							state_q <= S_REPLY;
						end else begin
							unique case (req.cmd) inside
								CMD_ADD:     state_q <= pend ? S_REPLY : S_INSERT;
								CMD_MODIFY:  state_q <= pend ? S_DETACH : S_INSERT;
								CMD_MOD_PND,
								CMD_DELETE:  state_q <= pend ? S_DETACH : S_REPLY;
								default:     state_q <= S_REPLY;
							endcase
						end
					end
				end
				S_DETACH: begin
					pending_q[id_q] <= 1'b0;
					state_q         <= del_q ? S_REPLY : S_INSERT;
				end
				S_INSERT: begin
					if (!tail_full) begin
						pending_q[id_q] <= 1'b1;
					end
					state_q <= S_REPLY;
				end
				S_REPLY: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_TICK: begin
					if (slot_free) begin
						if (fire_ok) begin
							pending_q[cell_owner[0]] <= 1'b0;
							if (last_fire) begin
								state_q <= S_IDLE;
							end
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Captured command word and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q       <= req.timer_id;
			exp_q      <= TIME_BITS'(req.expiry_time);
			now_q      <= TIME_BITS'(req.current_time);
			fire_cnt_q <= '0;
			// only delete stops after the removal; both modifies reinsert
			del_q      <= (req.cmd == CMD_DELETE);
			flt_q      <= id_ok && (req.cmd == CMD_ADD) && pend;
			was_q      <= id_ok && (req.cmd <= CMD_DELETE) && pend;
		end
		if (state_q == S_REPLY && slot_free) begin
			rsp_was_q   <= was_q;
			rsp_flt_q   <= flt_q;
			rsp_fired_q <= 1'b0;
			rsp_id_q    <= '0;
			rsp_last_q  <= 1'b1;
		end else if (state_q == S_TICK && slot_free) begin
			rsp_was_q   <= 1'b0;
			rsp_flt_q   <= 1'b0;
			rsp_fired_q <= fire_ok;
			rsp_id_q    <= fire_ok ? cell_owner[0] : '0;
			rsp_last_q  <= fire_ok ? last_fire : 1'b1;
			if (fire_ok) begin
				fire_cnt_q <= fire_cnt_q + FIRE_CNT_W'(1);
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.was_pending = rsp_was_q;
	assign rsp.fault       = rsp_flt_q;
	assign rsp.fired       = rsp_fired_q;
	assign rsp.fired_id    = rsp_id_q;
	assign rsp.last        = rsp_last_q;

endmodule

// ===== hw/rtl/stq_checker.sv =====
module stq_checker import stq_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input logic            rsp_was_pending,
	input logic            rsp_fault,
	input logic            rsp_fired,
	input logic [ID_W-1:0] rsp_fired_id,
	input logic            rsp_last
);

	// One command in flight: ready drops right after a word is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("command taken while another is in flight");

	// A stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid &&
		$stable({rsp_was_pending, rsp_fault, rsp_fired, rsp_fired_id, rsp_last}))
		else $error("result word changed while stalled");

	// A word naming no fired timer ends its command and carries id zero
	a_quiet_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_fired |-> rsp_last && (rsp_fired_id == '0))
		else $error("non-fire word not last or with stray id");

	// Fire words come from ticks only
	a_fire_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_fired |-> !rsp_was_pending && !rsp_fault)
		else $error("fire word with command status bits");

	// A fault is only raised for a pending timer
	a_fault_pending: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_fault |-> rsp_was_pending)
		else $error("fault without pending timer");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_was_pending (rsp.was_pending),
	.rsp_fault       (rsp.fault),
	.rsp_fired       (rsp.fired),
	.rsp_fired_id    (rsp.fired_id),
	.rsp_last        (rsp.last)
);
